/* sv/tts_pkg.sv */
// Shared types, character codes and classification functions for the token splitter.
`timescale 1ns / 1ps

package tts_pkg;

  // Parser mode codes.
  localparam logic [2:0] MODE_SKIP  = 3'd0;
  localparam logic [2:0] MODE_SLASH = 3'd1;
  localparam logic [2:0] MODE_CMT   = 3'd2;
  localparam logic [2:0] MODE_QOPEN = 3'd3;
  localparam logic [2:0] MODE_QUOTE = 3'd4;
  localparam logic [2:0] MODE_WORD  = 3'd5;

  // Character codes.
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_COLON   = 8'h3A;

  // Result queue geometry.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [7:0] token_byte;
    logic       token_last;
    logic       token_empty;
    logic       text_end;
  } result_t;

  // Everything one parsed byte pushes into the result queue.
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } parse_out_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b <= CH_SPACE) || b[7];
  endfunction

  function automatic logic is_punct(input logic [7:0] b);
    return (b == CH_LBRACE) || (b == CH_RBRACE) || (b == CH_RPAREN) ||
           (b == CH_LPAREN) || (b == CH_SQUOTE) || (b == CH_COLON);
  endfunction

  function automatic result_t mk(input logic [7:0] ch, input logic last,
                                 input logic empty, input logic tend);
    result_t r;
    r.token_byte  = ch;
    r.token_last  = last;
    r.token_empty = empty;
    r.text_end    = tend;
    return r;
  endfunction

endpackage

/* sv/tts_byte_if.sv */
// Channel interface that carries one text byte per request.
`timescale 1ns / 1ps

interface tts_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

/* sv/tts_token_if.sv */
// Channel interface that carries one token result per request.
`timescale 1ns / 1ps

interface tts_token_if;
  logic       valid;
  logic       ready;
  logic [7:0] token_byte;
  logic       token_last;
  logic       token_empty;
  logic       text_end;

  modport source (output valid, output token_byte, output token_last,
                  output token_empty, output text_end, input ready);
  modport sink (input valid, input token_byte, input token_last,
                input token_empty, input text_end, output ready);
endinterface

/* sv/text_token_splitter_unit.sv */
// Top level of the streaming text token splitter.
`timescale 1ns / 1ps

// Text token splitter.
// The text channel takes one byte per request; a zero byte ends the text and the
// next byte starts a new one. The token channel returns token bytes in order,
// one per request: token_last flags the final byte of a token, token_empty marks
// an empty quoted string and text_end marks the end of a text.
// Whitespace and line comments produce nothing; a byte produces zero, one or
// two results.
// A byte is captured in the input register at acceptance and parsed into the
// result queue once the queue has room for two results; its results are then
// offered on the token channel in order, behind any results already queued.
// Throughput: one byte per cycle while the queue has room. The token channel
// delivers one result per cycle while the receiver is ready, so bytes that
// produce two results make the queue fill; the four-entry result queue absorbs
// this, and input ready drops only when it lacks room for two more results.
// When the receiver stalls, results stay in the queue, the input register holds
// its byte and text ready falls once the queue is full enough.
// Reset (synchronous, active high) empties the queue and the input register and
// puts the parser in whitespace skip mode; text ready is high right after.
module text_token_splitter_unit (
  input  logic        clk,
  input  logic        rst,
  tts_byte_if.sink    text,
  tts_token_if.source token
);

  logic                s1_valid;
  logic [7:0]          s1_byte;
  logic                room;
  logic                go;
  tts_pkg::parse_out_t po;

  // The held byte is parsed as soon as the queue can take two results.
  assign go         = s1_valid && room;
  assign text.ready = !s1_valid || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (text.ready) begin
      s1_valid <= text.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      s1_byte <= text.text_byte;
    end
  end

  tts_parser u_parser (
    .clk (clk),
    .rst (rst),
    .go  (go),
    .b   (s1_byte),
    .po  (po)
  );

  tts_out_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .po    (po),
    .room  (room),
    .token (token)
  );

endmodule

/* sv/tts_parser.sv */
// Tokenizer state machine: classifies one byte and produces up to two results.
`timescale 1ns / 1ps

module tts_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  logic [7:0]          b,
  output tts_pkg::parse_out_t po
);

  logic [2:0] mode, mode_next;
  logic [7:0] held, held_next;

  always_comb begin
    po        = '0;
    mode_next = mode;
    held_next = held;
    case (mode)
      tts_pkg::MODE_SLASH, tts_pkg::MODE_WORD: begin
        if (mode == tts_pkg::MODE_SLASH && b == tts_pkg::CH_SLASH) begin
          mode_next = tts_pkg::MODE_CMT;
          held_next = '0;
        end else if (tts_pkg::is_punct(b)) begin
          po.r0     = tts_pkg::mk(held, 1'b1, 1'b0, 1'b0);
          po.r1     = tts_pkg::mk(b, 1'b1, 1'b0, 1'b0);
          po.count  = 2'd2;
          mode_next = tts_pkg::MODE_SKIP;
          held_next = '0;
        end else if (tts_pkg::is_space(b)) begin
          po.r0     = tts_pkg::mk(held, 1'b1, 1'b0, 1'b0);
          po.r1     = tts_pkg::mk(8'd0, 1'b0, 1'b0, 1'b1);
          po.count  = (b == tts_pkg::CH_NUL) ? 2'd2 : 2'd1;
          mode_next = tts_pkg::MODE_SKIP;
          held_next = '0;
        end else begin
          po.r0     = tts_pkg::mk(held, 1'b0, 1'b0, 1'b0);
          po.count  = 2'd1;
          mode_next = tts_pkg::MODE_WORD;
          held_next = b;
        end
      end
      tts_pkg::MODE_CMT: begin
        if (b == tts_pkg::CH_NUL) begin
          po.r0     = tts_pkg::mk(8'd0, 1'b0, 1'b0, 1'b1);
          po.count  = 2'd1;
          mode_next = tts_pkg::MODE_SKIP;
          held_next = '0;
        end else if (b == tts_pkg::CH_NEWLINE) begin
          mode_next = tts_pkg::MODE_SKIP;
          held_next = '0;
        end
      end
      tts_pkg::MODE_QOPEN, tts_pkg::MODE_QUOTE: begin
        if (b == tts_pkg::CH_DQUOTE || b == tts_pkg::CH_NUL) begin
          // An opened quote that closes at once is an empty token.
          po.r0     = (mode == tts_pkg::MODE_QOPEN) ?
                      tts_pkg::mk(8'd0, 1'b0, 1'b1, 1'b0) :
                      tts_pkg::mk(held, 1'b1, 1'b0, 1'b0);
          po.r1     = tts_pkg::mk(8'd0, 1'b0, 1'b0, 1'b1);
          po.count  = (b == tts_pkg::CH_NUL) ? 2'd2 : 2'd1;
          mode_next = tts_pkg::MODE_SKIP;
          held_next = '0;
        end else begin
          if (mode == tts_pkg::MODE_QUOTE) begin
            po.r0    = tts_pkg::mk(held, 1'b0, 1'b0, 1'b0);
            po.count = 2'd1;
          end
          mode_next = tts_pkg::MODE_QUOTE;
          held_next = b;
        end
      end
      default: begin
        mode_next = tts_pkg::MODE_SKIP;
        held_next = '0;
        if (b == tts_pkg::CH_NUL) begin
          po.r0    = tts_pkg::mk(8'd0, 1'b0, 1'b0, 1'b1);
          po.count = 2'd1;
        end else if (tts_pkg::is_space(b)) begin
          mode_next = tts_pkg::MODE_SKIP;
        end else if (b == tts_pkg::CH_SLASH) begin
          mode_next = tts_pkg::MODE_SLASH;
          held_next = b;
        end else if (b == tts_pkg::CH_DQUOTE) begin
          mode_next = tts_pkg::MODE_QOPEN;
        end else if (tts_pkg::is_punct(b)) begin
          po.r0    = tts_pkg::mk(b, 1'b1, 1'b0, 1'b0);
          po.count = 2'd1;
        end else begin
          mode_next = tts_pkg::MODE_WORD;
          held_next = b;
        end
      end
    endcase
    if (!go) begin
      po.count  = 2'd0;
      mode_next = mode;
      held_next = held;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= tts_pkg::MODE_SKIP;
      held <= '0;
    end else begin
      mode <= mode_next;
      held <= held_next;
    end
  end

endmodule

/* sv/tts_out_queue.sv */
// Small result queue: takes up to two results per cycle, delivers one.
`timescale 1ns / 1ps

module tts_out_queue (
  input  logic                clk,
  input  logic                rst,
  input  tts_pkg::parse_out_t po,
  output logic                room,
  tts_token_if.source         token
);

  localparam logic [tts_pkg::QUEUE_AW:0] ROOM_LIMIT = (tts_pkg::QUEUE_AW + 1)'(
    tts_pkg::QUEUE_DEPTH - 2);

  tts_pkg::result_t mem [tts_pkg::QUEUE_DEPTH];
  logic [tts_pkg::QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [tts_pkg::QUEUE_AW:0]   count;
  logic                         pop;
  tts_pkg::result_t             head;

  assign pop   = token.valid && token.ready;
  assign room  = count <= ROOM_LIMIT;
  assign head  = mem[rd_ptr];

  assign token.valid       = count != '0;
  assign token.token_byte  = head.token_byte;
  assign token.token_last  = head.token_last;
  assign token.token_empty = head.token_empty;
  assign token.text_end    = head.text_end;

  always_ff @(posedge clk) begin
    if (po.count != 2'd0) begin
      mem[wr_ptr] <= po.r0;
    end
    if (po.count == 2'd2) begin
      mem[wr_ptr + tts_pkg::QUEUE_AW'(1)] <= po.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + tts_pkg::QUEUE_AW'(po.count);
      if (pop) begin
        rd_ptr <= rd_ptr + tts_pkg::QUEUE_AW'(1);
      end
      count <= count + (tts_pkg::QUEUE_AW + 1)'(po.count) -
               (tts_pkg::QUEUE_AW + 1)'(pop);
    end
  end

endmodule

/* sv/tts_checker.sv */
// Port-level checks for the token splitter and the bind that attaches them.
`timescale 1ns / 1ps

module tts_checker (
  input logic       clk,
  input logic       rst,
  input logic       tok_valid,
  input logic       tok_ready,
  input logic [7:0] tok_byte,
  input logic       tok_last,
  input logic       tok_empty,
  input logic       tok_end,
  input logic       txt_ready
);

  // A stalled result stays offered.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    tok_valid && !tok_ready |=> tok_valid)
    else $error("token result dropped while stalled");

  // An end marker carries no character and closes no token by itself.
  a_end: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok_end |-> !tok_last && !tok_empty && tok_byte == 8'd0)
    else $error("malformed end marker");

  // An empty token carries no character.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok_empty |-> !tok_last && !tok_end && tok_byte == 8'd0)
    else $error("malformed empty token");

  // After reset nothing is offered and the text side is open.
  a_reset: assert property (@(posedge clk)
    rst |=> !tok_valid && txt_ready)
    else $error("state survived reset");

endmodule

bind text_token_splitter_unit tts_checker u_tts_checker (
  .clk       (clk),
  .rst       (rst),
  .tok_valid (token.valid),
  .tok_ready (token.ready),
  .tok_byte  (token.token_byte),
  .tok_last  (token.token_last),
  .tok_empty (token.token_empty),
  .tok_end   (token.text_end),
  .txt_ready (text.ready)
);

/* sim/tb_text_token_splitter_unit.sv */
// Self-checking testbench for the streaming text token splitter.
`timescale 1ns / 1ps

// The bench sends text bytes on the text channel and checks every token result
// that comes back. Each accepted request on the text channel goes through an
// in-bench tokenizer that keeps its own parse mode and held byte. That tokenizer
// queues the token results the byte must cause. The token channel side pops the
// oldest queued result for each accepted request and compares it field by field.
// The stimulus has three parts. A short directed run covers the field extremes,
// every punctuation token and the corner cases of the grammar. A sender pause
// test lets the result queue drain completely before it goes on. The random part
// is mostly well-formed texts with random content, mixed with runs of raw noise
// bytes. Both channels idle and stall at random, with stretches of full speed
// between.
module tb_text_token_splitter_unit;

  // Enough text bytes in total to reach deep into the grammar many times over.
  localparam int TOTAL_BYTES = 1250;
  // Quiet cycles allowed before the run is declared hung. The slowest correct
  // stretch is a sender gap plus two receiver stalls.
  localparam int QUIET_LIMIT = 1000;
  localparam int PRINT_CAP   = 40;

  // Kinds of token that the random text generator strings together.
  typedef enum int {
    TK_WORD,
    TK_SLASH_WORD,
    TK_QUOTE,
    TK_PUNCT,
    TK_COMMENT
  } tok_kind_t;

  logic clk;
  logic rst;

  tts_byte_if  text_ch ();
  tts_token_if token_ch ();

  text_token_splitter_unit dut (
    .clk   (clk),
    .rst   (rst),
    .text  (text_ch),
    .token (token_ch)
  );

  // Tokenizer state of the bench, kept in step with accepted text requests.
  logic [2:0] scan_mode;
  logic [7:0] held_byte;
  logic       held_ok;

  // Token results that accepted bytes have caused and that have not come back yet.
  tts_pkg::result_t tokens_due[$];

  // Idle switches: when cleared, that side runs at full speed.
  bit gap_on;
  bit stall_on;

  int mismatch_count;
  int bytes_sent;
  int texts_sent;
  int results_seen;
  int empties_seen;
  int ends_seen;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Tokenizer of the bench.
  // ---------------------------------------------------------------------------

  // Bytes 0 to 32 and every byte with the top bit set separate tokens.
  function automatic logic is_blank_byte(input logic [7:0] b);
    return (b <= 8'd32) || (b >= 8'd128);
  endfunction

  // Braces, parentheses, the single quote and the colon are tokens on their own.
  function automatic logic is_single_token(input logic [7:0] b);
    return (b == tts_pkg::CH_LBRACE) || (b == tts_pkg::CH_RBRACE) ||
           (b == tts_pkg::CH_LPAREN) || (b == tts_pkg::CH_RPAREN) ||
           (b == tts_pkg::CH_SQUOTE) || (b == tts_pkg::CH_COLON);
  endfunction

  function automatic void expect_token(input logic [7:0] ch, input logic last,
                                       input logic empty, input logic tend);
    tts_pkg::result_t r;
    r.token_byte  = ch;
    r.token_last  = last;
    r.token_empty = empty;
    r.text_end    = tend;
    tokens_due.push_back(r);
  endfunction

  function automatic void clear_held();
    held_byte = 8'h00;
    held_ok   = 1'b0;
    scan_mode = tts_pkg::MODE_SKIP;
  endfunction

  function automatic void hold_byte(input logic [7:0] b, input logic [2:0] next_mode);
    held_byte = b;
    held_ok   = 1'b1;
    scan_mode = next_mode;
  endfunction

  // Advances the tokenizer by one accepted byte and queues what it produces.
  // In a word or a string the byte before the current one is held back, so the
  // final byte of a token only leaves once the byte after it shows where the token ends.
  function automatic void predict_byte(input logic [7:0] b);
    logic blank;
    logic single;
    blank  = is_blank_byte(b);
    single = is_single_token(b);
    case (scan_mode)
      tts_pkg::MODE_SLASH, tts_pkg::MODE_WORD: begin
        if (scan_mode == tts_pkg::MODE_SLASH && b == tts_pkg::CH_SLASH) begin
          // Two slashes open a comment and the held slash is dropped.
          clear_held();
          scan_mode = tts_pkg::MODE_CMT;
        end else if (single) begin
          // The word ends and the punctuation follows in the same step.
          expect_token(held_byte, 1'b1, 1'b0, 1'b0);
          expect_token(b, 1'b1, 1'b0, 1'b0);
          clear_held();
        end else if (blank) begin
          expect_token(held_byte, 1'b1, 1'b0, 1'b0);
          if (b == tts_pkg::CH_NUL) expect_token(tts_pkg::CH_NUL, 1'b0, 1'b0, 1'b1);
          clear_held();
        end else begin
          expect_token(held_byte, 1'b0, 1'b0, 1'b0);
          hold_byte(b, tts_pkg::MODE_WORD);
        end
      end
      tts_pkg::MODE_CMT: begin
        if (b == tts_pkg::CH_NUL) begin
          expect_token(tts_pkg::CH_NUL, 1'b0, 1'b0, 1'b1);
          clear_held();
        end else if (b == tts_pkg::CH_NEWLINE) begin
          clear_held();
        end
      end
      tts_pkg::MODE_QOPEN: begin
        if (b == tts_pkg::CH_DQUOTE || b == tts_pkg::CH_NUL) begin
          // Nothing between the quotes: an empty token.
          expect_token(tts_pkg::CH_NUL, 1'b0, 1'b1, 1'b0);
          if (b == tts_pkg::CH_NUL) expect_token(tts_pkg::CH_NUL, 1'b0, 1'b0, 1'b1);
          clear_held();
        end else begin
          hold_byte(b, tts_pkg::MODE_QUOTE);
        end
      end
      tts_pkg::MODE_QUOTE: begin
        if (b == tts_pkg::CH_DQUOTE || b == tts_pkg::CH_NUL) begin
          expect_token(held_byte, 1'b1, 1'b0, 1'b0);
          if (b == tts_pkg::CH_NUL) expect_token(tts_pkg::CH_NUL, 1'b0, 1'b0, 1'b1);
          clear_held();
        end else begin
          expect_token(held_byte, 1'b0, 1'b0, 1'b0);
          hold_byte(b, tts_pkg::MODE_QUOTE);
        end
      end
      default: begin
        // Whitespace skipping; the unused mode codes behave the same way.
        clear_held();
        if (b == tts_pkg::CH_NUL) begin
          expect_token(tts_pkg::CH_NUL, 1'b0, 1'b0, 1'b1);
        end else if (blank) begin
          // Nothing to do.
        end else if (b == tts_pkg::CH_SLASH) begin
          hold_byte(b, tts_pkg::MODE_SLASH);
        end else if (b == tts_pkg::CH_DQUOTE) begin
          scan_mode = tts_pkg::MODE_QOPEN;
        end else if (single) begin
          expect_token(b, 1'b1, 1'b0, 1'b0);
        end else begin
          hold_byte(b, tts_pkg::MODE_WORD);
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Random characters for the text generator.
  // ---------------------------------------------------------------------------

  // A word character. The first one of a word is neither a quote nor a slash,
  // so that it really starts a word; later ones may be either.
  function automatic logic [7:0] word_char(input bit first);
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(33, 127));
    end while (is_single_token(c) ||
               (first && (c == tts_pkg::CH_DQUOTE || c == tts_pkg::CH_SLASH)));
    return c;
  endfunction

  function automatic logic [7:0] blank_char();
    return $urandom_range(0, 1) ? 8'($urandom_range(1, 32)) : 8'($urandom_range(128, 255));
  endfunction

  // Anything but the terminator and the closing quote may stand in a string.
  function automatic logic [7:0] quoted_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(1, 255));
    end while (c == tts_pkg::CH_DQUOTE);
    return c;
  endfunction

  function automatic logic [7:0] comment_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(1, 255));
    end while (c == tts_pkg::CH_NEWLINE);
    return c;
  endfunction

  function automatic logic [7:0] single_char();
    case ($urandom_range(0, 5))
      0:       return tts_pkg::CH_LBRACE;
      1:       return tts_pkg::CH_RBRACE;
      2:       return tts_pkg::CH_LPAREN;
      3:       return tts_pkg::CH_RPAREN;
      4:       return tts_pkg::CH_SQUOTE;
      default: return tts_pkg::CH_COLON;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Text channel driver.
  // ---------------------------------------------------------------------------

  // Offers one byte and returns at the edge where the request is accepted. The
  // valid line stays high on return, so a following byte with no gap goes out
  // back to back without valid dropping in between.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = gap_on ? $urandom_range(0, 16) : 0;
    if (gap != 0) begin
      text_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_ch.valid     <= 1'b1;
    text_ch.text_byte <= b;
    do @(posedge clk); while (!text_ch.ready);
    predict_byte(b);
    bytes_sent++;
    if (b == tts_pkg::CH_NUL) texts_sent++;
  endtask

  // Takes the text channel out of the valid state before any wait.
  task automatic idle_text();
    text_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (tokens_due.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Text generators.
  // ---------------------------------------------------------------------------

  // A text of a few random tokens, closed by the terminating zero byte. The last
  // string or comment is sometimes left open so that the terminator closes it.
  task automatic send_random_text();
    int        n_tokens;
    int        len;
    bit        is_last;
    tok_kind_t kind;
    n_tokens = $urandom_range(1, 8);
    for (int t = 0; t < n_tokens; t++) begin
      is_last = (t == n_tokens - 1);
      kind    = tok_kind_t'($urandom_range(0, 4));
      case (kind)
        TK_WORD: begin
          len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
          send_byte(word_char(1'b1));
          repeat (len - 1) send_byte(word_char(1'b0));
        end
        TK_SLASH_WORD: begin
          // A lone slash that starts a word instead of a comment.
          len = $urandom_range(0, 4);
          send_byte(tts_pkg::CH_SLASH);
          if (len != 0) send_byte(word_char(1'b1));
          repeat (len - 1) send_byte(word_char(1'b0));
        end
        TK_QUOTE: begin
          len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
          send_byte(tts_pkg::CH_DQUOTE);
          repeat (len) send_byte(quoted_char());
          if (!(is_last && $urandom_range(0, 2) == 0)) send_byte(tts_pkg::CH_DQUOTE);
        end
        TK_PUNCT: begin
          send_byte(single_char());
        end
        default: begin
          len = $urandom_range(0, 6);
          send_byte(tts_pkg::CH_SLASH);
          send_byte(tts_pkg::CH_SLASH);
          repeat (len) send_byte(comment_char());
          if (!(is_last && $urandom_range(0, 2) == 0)) send_byte(tts_pkg::CH_NEWLINE);
        end
      endcase
      // Most tokens get a separator; without one, neighbors may run together.
      if ($urandom_range(0, 9) < 7) begin
        repeat ($urandom_range(1, 3)) send_byte(blank_char());
      end
    end
    send_byte(tts_pkg::CH_NUL);
  endtask

  // Raw bytes of any value, which leave the parser in whatever mode they reach.
  task automatic send_noise();
    repeat ($urandom_range(1, 24)) send_byte(8'($urandom_range(0, 255)));
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  task automatic test_directed_cases();
    logic [7:0] seq[$];
    gap_on   = 1'b1;
    stall_on = 1'b1;
    seq = '{
      // A word holding a quote, a slash and the highest word byte 7F, which
      // ends on an opening brace in the same step.
      8'h21, tts_pkg::CH_DQUOTE, tts_pkg::CH_SLASH, 8'h7F, tts_pkg::CH_LBRACE,
      // Blanks at both ends of the range: the top byte and the lowest nonzero one.
      8'hFF, 8'h01,
      // An empty quoted string.
      tts_pkg::CH_DQUOTE, tts_pkg::CH_DQUOTE,
      // A lone slash ended by a space is a word of its own.
      tts_pkg::CH_SLASH, tts_pkg::CH_SPACE,
      // A comment up to the newline.
      tts_pkg::CH_SLASH, tts_pkg::CH_SLASH, 8'h63, tts_pkg::CH_NEWLINE,
      // The remaining single-character tokens.
      tts_pkg::CH_LPAREN, tts_pkg::CH_RPAREN, tts_pkg::CH_RBRACE,
      tts_pkg::CH_SQUOTE, tts_pkg::CH_COLON,
      // A string that the end of the text closes.
      tts_pkg::CH_DQUOTE, 8'h71, tts_pkg::CH_NUL,
      // An empty string that the end of the text closes.
      tts_pkg::CH_DQUOTE, tts_pkg::CH_NUL,
      // A comment that runs into the end of the text.
      tts_pkg::CH_SLASH, tts_pkg::CH_SLASH, tts_pkg::CH_NUL,
      // A text with nothing in it.
      tts_pkg::CH_NUL
    };
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // The sender runs flat out against a stalling receiver, then stops until every
  // result has come back, then resumes against a receiver that never stalls.
  task automatic test_sender_pause();
    gap_on   = 1'b0;
    stall_on = 1'b1;
    send_byte(tts_pkg::CH_DQUOTE);
    repeat (40) send_byte(quoted_char());
    send_byte(tts_pkg::CH_DQUOTE);
    repeat (4) send_byte(word_char(1'b1));
    send_byte(tts_pkg::CH_RPAREN);
    send_byte(tts_pkg::CH_NUL);
    idle_text();
    wait_drained();
    stall_on = 1'b0;
    send_random_text();
    send_random_text();
  endtask

  task automatic test_random_texts();
    while (bytes_sent < TOTAL_BYTES) begin
      // Each text gets its own idle setting on each side, so that full-speed
      // stretches alternate with gaps and stalls.
      gap_on   = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 7) == 0) send_noise();
      else send_random_text();
      if ($urandom_range(0, 24) == 0) begin
        idle_text();
        wait_drained();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Token channel: stalls and checking.
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_CAP) $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // Draws a stall before each request, then takes the result and compares it
  // with the oldest queued expectation.
  initial begin : token_sink
    int               stall;
    tts_pkg::result_t want;
    token_ch.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      stall = stall_on ? $urandom_range(0, 16) : 0;
      if (stall != 0) begin
        token_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      token_ch.ready <= 1'b1;
      do @(posedge clk); while (!token_ch.valid);
      results_seen++;
      if (token_ch.token_empty) empties_seen++;
      if (token_ch.text_end) ends_seen++;
      if (tokens_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte=%h last=%b empty=%b end=%b",
                                  token_ch.token_byte, token_ch.token_last,
                                  token_ch.token_empty, token_ch.text_end));
      end else begin
        want = tokens_due.pop_front();
        if (token_ch.token_byte !== want.token_byte)
          report_mismatch($sformatf("result %0d token_byte %h, expected %h",
                                    results_seen, token_ch.token_byte, want.token_byte));
        if (token_ch.token_last !== want.token_last)
          report_mismatch($sformatf("result %0d token_last %b, expected %b",
                                    results_seen, token_ch.token_last, want.token_last));
        if (token_ch.token_empty !== want.token_empty)
          report_mismatch($sformatf("result %0d token_empty %b, expected %b",
                                    results_seen, token_ch.token_empty, want.token_empty));
        if (token_ch.text_end !== want.text_end)
          report_mismatch($sformatf("result %0d text_end %b, expected %b",
                                    results_seen, token_ch.text_end, want.text_end));
      end
    end
  end

  // Ends the run if neither channel accepts a request for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (text_ch.valid && text_ch.ready) || (token_ch.valid && token_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Timeout: no request accepted for %0d cycles, %0d results pending",
             QUIET_LIMIT, tokens_due.size());
    $display("[text_token_splitter_unit] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------

  initial begin
    rst               <= 1'b1;
    text_ch.valid     <= 1'b0;
    text_ch.text_byte <= 8'h00;
    gap_on         = 1'b1;
    stall_on       = 1'b1;
    mismatch_count = 0;
    bytes_sent     = 0;
    texts_sent     = 0;
    results_seen   = 0;
    empties_seen   = 0;
    ends_seen      = 0;
    clear_held();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_sender_pause();
    test_random_texts();

    // Let every result come back, then watch a little longer for strays.
    idle_text();
    wait_drained();
    repeat (12) @(posedge clk);
    if (tokens_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", tokens_due.size()));

    $display("Sent %0d text bytes (%0d terminators) as directed cases, random texts and noise.",
             bytes_sent, texts_sent);
    $display("Checked %0d token results, %0d of them empty strings and %0d end markers.",
             results_seen, empties_seen, ends_seen);
    if (mismatch_count == 0) begin
      $display("[text_token_splitter_unit] OK");
    end else begin
      $display("[text_token_splitter_unit] ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/tts_pkg.sv
sv/tts_byte_if.sv
sv/tts_token_if.sv
sv/tts_parser.sv
sv/tts_out_queue.sv
sv/text_token_splitter_unit.sv
sv/tts_checker.sv
sim/tb_text_token_splitter_unit.sv
